// ----- hdl/pds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the pulse dialer sequencer.
// ----------------------------------------------------------------------------
package pds_pkg;

	// Item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TALK_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TALK_LONG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LISTEN = 2'd2;

	// Digit codes: 1..15 pulse counts, pause mark, 0 when finished
	localparam int unsigned CODE_W = 5;
	localparam logic [CODE_W-1:0] CODE_DONE  = 5'd0;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 5'd10;
	localparam logic [CODE_W-1:0] PAUSE_MARK = 5'd16;

	// Character classes
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;

	// Tick and second timings
	localparam logic [7:0] T_PAUSE = 8'd250;
	localparam logic [7:0] T_BREAK = 8'd15;
	localparam logic [7:0] T_MAKE  = 8'd7;
	localparam logic [7:0] T_GAP   = 8'd125;
	localparam logic [7:0] S_START = 8'd2;
	localparam logic [7:0] S_WAIT  = 8'd5;
	localparam logic [7:0] S_GUARD = 8'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DIAL = 2'd1,
		PH_WAIT = 2'd2,
		PH_TALK = 2'd3
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] char_in;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic       line_pulse;
		logic       relay_out;
		logic       connected;
		phase_t     phase;
	} result_t;

	typedef struct packed {
		logic [7:0] talk_time_short;
		logic [7:0] talk_time_long;
		logic       long_listen;
	} cfg_regs_t;

endpackage

// ----- hdl/pds_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_if
// Valid/ready channels of the pulse dialer: items, results, register writes.
// ----------------------------------------------------------------------------
interface pds_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, op, char_in, last_char, input ready);
	modport sink   (input valid, op, char_in, last_char, output ready);
endinterface

interface pds_result_if;
	logic       valid;
	logic       ready;
	logic       line_pulse;
	logic       relay_out;
	logic       connected;
	logic [1:0] phase;

	modport source (output valid, line_pulse, relay_out, connected, phase, input ready);
	modport sink   (input valid, line_pulse, relay_out, connected, phase, output ready);
endinterface

interface pds_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/pds_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/pds_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_core
// Sequencer state and next-state logic; drives the digit store with bypass.
// ----------------------------------------------------------------------------
module pds_core
	import pds_pkg::*;
#(
	parameter int unsigned MAX_DIGITS       = 16,
	parameter int unsigned TICKS_PER_SECOND = 100,
	localparam int unsigned AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
	localparam int unsigned CW  = $clog2(MAX_DIGITS + 1),
	localparam int unsigned TKW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  item_t             item_s1,
	input  cfg_regs_t         regs,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [CODE_W-1:0] ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [CODE_W-1:0] ram_rdata,
	output result_t           res_d
);

	localparam logic [CW-1:0]  MAX_C   = CW'(MAX_DIGITS);
	localparam logic [TKW:0]   TPS_C   = (TKW + 1)'(TICKS_PER_SECOND);

	function automatic logic [AW-1:0] clamp_idx(input logic [CW-1:0] pos);
		logic [CW-1:0] c;
		c = (pos >= MAX_C) ? CW'(MAX_DIGITS - 1) : pos;
		return c[AW-1:0];
	endfunction

	logic [CW-1:0]      digit_total_q, load_pos_q, dial_pos_q;
	logic               load_ended_q, make_half_q, line_q, relay_q, conn_q;
	phase_t             phase_q;
	logic [7:0]         pulse_timer_q, second_timer_q;
	logic [TKW-1:0]     tick_q;
	logic               byp_hit_q;
	logic [CODE_W-1:0]  byp_data_q;

	logic [CW-1:0]      digit_total_n, load_pos_n, dial_pos_n, dial_pos_d;
	logic               load_ended_n, make_half_n, line_n, relay_n, conn_n;
	phase_t             phase_n;
	logic [7:0]         pulse_timer_n, second_timer_n;
	logic [TKW-1:0]     tick_n;
	logic [TKW:0]       tick_inc;
	logic [CODE_W-1:0]  cur, code;
	logic               we_c;
	logic [AW-1:0]      waddr_c;
	logic [CODE_W-1:0]  wdata_c;

	// Current entry: take the bypass when the last write hit the read address
	assign cur = byp_hit_q ? byp_data_q : ram_rdata;

	always_comb begin
		digit_total_n  = digit_total_q;
		load_pos_n     = load_pos_q;
		load_ended_n   = load_ended_q;
		dial_pos_n     = dial_pos_q;
		phase_n        = phase_q;
		pulse_timer_n  = pulse_timer_q;
		second_timer_n = second_timer_q;
		tick_n         = tick_q;
		make_half_n    = make_half_q;
		line_n         = line_q;
		relay_n        = relay_q;
		conn_n         = conn_q;
		we_c           = 1'b0;
		waddr_c        = clamp_idx(dial_pos_q);
		wdata_c        = CODE_DONE;
		code           = CODE_DONE;
		tick_inc       = '0;

		if (item_s1.op == OP_LOAD) begin
			if (phase_q == PH_IDLE) begin
				if (!load_ended_q && (load_pos_q < MAX_C)) begin
					if (item_s1.char_in <= CHAR_SPACE) begin
						load_ended_n = 1'b1;
					end else begin
						if (item_s1.char_in == CHAR_DASH) begin
							code = PAUSE_MARK;
						end else begin
							code = {1'b0, item_s1.char_in[3:0]};
							if (code == CODE_DONE) begin
								code = CODE_ZERO;
							end
						end
						we_c       = 1'b1;
						waddr_c    = load_pos_q[AW-1:0];
						wdata_c    = code;
						load_pos_n = load_pos_q + CW'(1);
						if (load_pos_n >= MAX_C) begin
							load_ended_n = 1'b1;
						end
					end
				end
				if (item_s1.last_char) begin
					if (load_pos_n != '0) begin
						digit_total_n  = load_pos_n;
						dial_pos_n     = '0;
						phase_n        = PH_DIAL;
						tick_n         = '0;
						second_timer_n = S_START;
						make_half_n    = 1'b1;
						line_n         = 1'b1;
						conn_n         = 1'b1;
						pulse_timer_n  = T_PAUSE;
					end
					load_pos_n   = '0;
					load_ended_n = 1'b0;
				end
			end
		end else begin
			// Timers first
			if (pulse_timer_q != '0) begin
				pulse_timer_n = pulse_timer_q - 8'd1;
			end
			tick_inc = {1'b0, tick_q} + (TKW + 1)'(1);
			if (tick_inc >= TPS_C) begin
				tick_n = '0;
				if (second_timer_q != '0) begin
					second_timer_n = second_timer_q - 8'd1;
				end
			end else begin
				tick_n = tick_inc[TKW-1:0];
			end

			// Pulse train for the current digit
			if ((phase_q == PH_DIAL) && (pulse_timer_n == '0)) begin
				if (cur == PAUSE_MARK) begin
					pulse_timer_n = T_PAUSE;
					we_c          = 1'b1;
					wdata_c       = CODE_DONE;
				end else if (cur != CODE_DONE) begin
					line_n      = ~line_q;
					make_half_n = ~make_half_q;
					if (make_half_n) begin
						we_c          = 1'b1;
						wdata_c       = cur - CODE_W'(1);
						pulse_timer_n = T_MAKE;
					end else begin
						pulse_timer_n = T_BREAK;
					end
				end else begin
					dial_pos_n    = dial_pos_q + CW'(1);
					pulse_timer_n = T_GAP;
					if (dial_pos_n >= digit_total_q) begin
						phase_n        = PH_WAIT;
						tick_n         = '0;
						second_timer_n = S_WAIT;
					end
				end
			end

			if ((phase_n == PH_WAIT) && (second_timer_n == '0)) begin
				relay_n        = 1'b0;
				tick_n         = '0;
				second_timer_n = regs.long_listen ? regs.talk_time_long : regs.talk_time_short;
				phase_n        = PH_TALK;
			end

			if ((phase_n == PH_TALK) && (second_timer_n == '0)) begin
				conn_n         = 1'b0;
				phase_n        = PH_IDLE;
				line_n         = 1'b0;
				relay_n        = 1'b1;
				tick_n         = '0;
				second_timer_n = S_GUARD;
			end
		end
	end

	// Read ahead at the position the next item will see
	assign dial_pos_d = fire ? dial_pos_n : dial_pos_q;
	assign ram_raddr  = clamp_idx(dial_pos_d);
	assign ram_we     = fire & we_c;
	assign ram_waddr  = waddr_c;
	assign ram_wdata  = wdata_c;

	assign res_d.line_pulse = line_n;
	assign res_d.relay_out  = relay_n;
	assign res_d.connected  = conn_n;
	assign res_d.phase      = phase_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_total_q  <= '0;
			load_pos_q     <= '0;
			load_ended_q   <= 1'b0;
			dial_pos_q     <= '0;
			phase_q        <= PH_IDLE;
			pulse_timer_q  <= '0;
			second_timer_q <= '0;
			tick_q         <= '0;
			make_half_q    <= 1'b0;
			line_q         <= 1'b0;
			relay_q        <= 1'b1;
			conn_q         <= 1'b0;
			byp_hit_q      <= 1'b0;
		end else begin
			if (fire) begin
				digit_total_q  <= digit_total_n;
				load_pos_q     <= load_pos_n;
				load_ended_q   <= load_ended_n;
				dial_pos_q     <= dial_pos_n;
				phase_q        <= phase_n;
				pulse_timer_q  <= pulse_timer_n;
				second_timer_q <= second_timer_n;
				tick_q         <= tick_n;
				make_half_q    <= make_half_n;
				line_q         <= line_n;
				relay_q        <= relay_n;
				conn_q         <= conn_n;
			end
			byp_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ram_wdata;
	end

endmodule

// ----- hdl/pulse_dialer_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_dialer_sequencer_top
// Pulse dialer: loads a number, then dials it as break/make pulses on ticks.
// ----------------------------------------------------------------------------
// Each input beat is either a number character (op 0) or one timer tick
// (op 1), and each one yields exactly one result beat with the line, relay,
// connected and phase outputs as they stand after that beat. The block
// takes one beat per clock while results are taken: a beat is held in the
// execute stage, where the scalar state is updated and the digit store
// entry read ahead is modified, and its result is loaded into the output
// register when the stage advances, after which it is valid until taken.
// The digit store is a MAX_DIGITS x 5 RAM with registered read data; its
// read address is steered by the execute stage's next dial position and
// a one-entry bypass covers a write and a read to the same entry on the
// same edge, so ticks may arrive back to back. The input channel keeps
// accepting while a result waits, as long as the execute stage is free
// or draining. Register writes are taken at any time and should only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
module pulse_dialer_sequencer_top
	import pds_pkg::*;
#(
	parameter int unsigned MAX_DIGITS       = 16,
	parameter int unsigned TICKS_PER_SECOND = 100
) (
	input  logic           clk,
	input  logic           arst_n,
	pds_item_if.sink       item,
	pds_result_if.source   result,
	pds_cfg_if.sink        cfg
);

	localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// Execute stage and output register
	logic       s1_valid_q;
	item_t      item_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_d;
	logic       s1_fire;
	logic       in_acc;

	// Configuration registers
	cfg_regs_t  regs_q;

	// Digit store port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CODE_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CODE_W-1:0] ram_rdata;

	// Advance the execute stage when the output register is free or drains
	assign s1_fire    = s1_valid_q && (!out_valid_q || result.ready);
	assign item.ready = !s1_valid_q || s1_fire;
	assign in_acc     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= in_acc || (s1_valid_q && !s1_fire);
			out_valid_q <= s1_fire || (out_valid_q && !result.ready);
		end
	end

	// Hold the payloads until the next beat moves in
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.op        <= item.op;
			item_s1.char_in   <= item.char_in;
			item_s1.last_char <= item.last_char;
		end
		if (s1_fire) begin
			res_q <= res_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.line_pulse = res_q.line_pulse;
	assign result.relay_out  = res_q.relay_out;
	assign result.connected  = res_q.connected;
	assign result.phase      = res_q.phase;

	// Register writes; indexes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.talk_time_short <= 8'd55;
			regs_q.talk_time_long  <= 8'd55;
			regs_q.long_listen     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TALK_SHORT:  regs_q.talk_time_short <= cfg.data;
				REG_TALK_LONG:   regs_q.talk_time_long  <= cfg.data;
				REG_LONG_LISTEN: regs_q.long_listen     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	pds_ram #(
		.WIDTH (CODE_W),
		.DEPTH (MAX_DIGITS)
	) u_digit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pds_core #(
		.MAX_DIGITS       (MAX_DIGITS),
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.item_s1   (item_s1),
		.regs      (regs_q),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_d     (res_d)
	);

endmodule
